### sv/lzenc_pkg.sv
// shared types and constants for the lz sequence token encoder
`default_nettype none

package lzenc_pkg;

    localparam int LEN_BITS    = 13;
    localparam int OFF_BITS    = 17;
    localparam int MIN_W       = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [MIN_W-1:0]   MIN_MATCH_RESET = 5'd4;
    localparam logic [LEN_BITS-1:0] EXT_BASE       = LEN_BITS'(7);
    localparam logic [LEN_BITS-1:0] EXT_CHUNK      = LEN_BITS'(255);
    localparam logic [7:0]          CHUNK_BYTE     = 8'hff;

    localparam logic CMD_HEADER  = 1'b0;
    localparam logic CMD_LITERAL = 1'b1;

    typedef struct packed {
        logic [7:0]          first_byte;
        logic                zero_byte;
        logic                lit_ext;
        logic [LEN_BITS-1:0] ext_len;
        logic                fin;
        logic                lit_only;
        logic                short_form;
        logic [OFF_BITS-1:0] offset;
        logic [LEN_BITS-1:0] match;
    } lzenc_job_t;

    function automatic logic [2:0] min7(input logic [LEN_BITS-1:0] v);
        min7 = (v < EXT_BASE) ? v[2:0] : 3'd7;
    endfunction

endpackage

`default_nettype wire

### sv/lzenc_front.sv
// front part: accepts items, tracks the open sequence and builds byte jobs
`default_nettype none

module lzenc_front
    import lzenc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire logic                full,
    input  wire logic                cmd,
    input  wire logic [16:0]         match_offset,
    input  wire logic [12:0]         match_length,
    input  wire logic [12:0]         literal_count,
    input  wire logic [7:0]          literal_byte,
    input  wire logic                cfg_valid,
    input  wire logic [MIN_W-1:0]    cfg_data,
    output lzenc_job_t               job,
    output logic                     job_push
);

    logic [MIN_W-1:0]    min_match_reg;
    logic [OFF_BITS-1:0] offset_reg;
    logic [LEN_BITS-1:0] match_reg;
    logic [LEN_BITS-1:0] left_reg;
    logic                short_reg;
    logic                lonly_reg;

    logic                accept;
    logic [LEN_BITS-1:0] ml;
    logic [LEN_BITS-1:0] lc;
    logic [LEN_BITS-1:0] min_ext;
    logic [LEN_BITS-1:0] m;
    logic                h_lonly;
    logic                h_short;
    logic [7:0]          token;

    assign accept  = push && !full;
    assign ml      = match_length[LEN_BITS-1:0];
    assign lc      = literal_count[LEN_BITS-1:0];
    assign min_ext = LEN_BITS'(min_match_reg);
    assign m       = (ml > min_ext) ? (ml - min_ext) : '0;
    assign h_lonly = (match_offset == '0);
    assign h_short = !h_lonly && (match_offset < OFF_BITS'(1 << 10)) && (lc < LEN_BITS'(4));

    always_comb
    begin
        if (h_lonly)
        begin
            token = {1'b1, 4'b0000, min7(lc)};
        end
        else if (h_short)
        begin
            token = {1'b1, match_offset[9:8], lc[1:0], min7(m)};
        end
        else
        begin
            token = {1'b0, match_offset[16], min7(lc), min7(m)};
        end
    end

    always_comb
    begin
        job      = '0;
        job_push = 1'b0;
        if (cmd == CMD_HEADER)
        begin
            job_push        = accept;
            job.first_byte  = token;
            job.zero_byte   = h_lonly;
            job.lit_ext     = !h_short && (lc >= EXT_BASE);
            job.ext_len     = lc;
            job.fin         = (lc == '0);
            job.lit_only    = h_lonly;
            job.short_form  = h_short;
            job.offset      = match_offset;
            job.match       = h_lonly ? '0 : m;
        end
        else
        begin
            job_push        = accept && (left_reg != '0);
            job.first_byte  = literal_byte;
            job.fin         = (left_reg == LEN_BITS'(1));
            job.lit_only    = lonly_reg;
            job.short_form  = short_reg;
            job.offset      = offset_reg;
            job.match       = match_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_match_reg <= MIN_MATCH_RESET;
            offset_reg    <= '0;
            match_reg     <= '0;
            left_reg      <= '0;
            short_reg     <= 1'b0;
            lonly_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                min_match_reg <= cfg_data;
            end
            if (accept && (cmd == CMD_HEADER))
            begin
                offset_reg <= match_offset;
                match_reg  <= h_lonly ? '0 : m;
                left_reg   <= lc;
                short_reg  <= h_short;
                lonly_reg  <= h_lonly;
            end
            else if (job_push)
            begin
                left_reg <= left_reg - LEN_BITS'(1);
            end
        end
    end

endmodule

`default_nettype wire

### sv/lzenc_queue.sv
// short job queue between the front and back parts
`default_nettype none

module lzenc_queue
    import lzenc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire lzenc_job_t  wr_data,
    output logic             full,
    input  wire logic        rd_en,
    output lzenc_job_t       rd_data,
    output logic             rd_valid
);

    lzenc_job_t          entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic                do_wr;
    logic                do_rd;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entries[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + (QPTR_W+1)'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

### sv/lzenc_back.sv
// back part: byte sequencer that turns one job into stream bytes
`default_nettype none

module lzenc_back
    import lzenc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire lzenc_job_t  q_data,
    input  wire logic        q_valid,
    output logic             q_pop,
    input  wire logic        pop,
    output logic             empty,
    output logic [7:0]       out_byte,
    output logic             last,
    output logic             sequence_done
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FIRST,
        PH_ZERO,
        PH_LEXT,
        PH_OFF0,
        PH_OFF1,
        PH_MEXT
    } phase_t;

    phase_t              phase_reg;
    phase_t              phase_next;
    phase_t              fin_ph;
    phase_t              mext_ph;
    lzenc_job_t          job_reg;
    logic [LEN_BITS-1:0] rest_reg;
    logic [LEN_BITS-1:0] rest_next;
    logic                out_valid_reg;
    logic [7:0]          out_byte_reg;
    logic                last_reg;
    logic                done_reg;

    logic                emit;
    logic                done;
    logic                chunk_full;
    logic [7:0]          chunk;
    logic [7:0]          cur_byte;

    assign empty         = !out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign last          = last_reg;
    assign sequence_done = done_reg;

    assign chunk_full = (rest_reg >= EXT_CHUNK);
    assign chunk      = chunk_full ? CHUNK_BYTE : rest_reg[7:0];
    assign emit       = (phase_reg != PH_IDLE) && (!out_valid_reg || pop);
    assign fin_ph     = (job_reg.fin && !job_reg.lit_only) ? PH_OFF0 : PH_IDLE;
    assign mext_ph    = (job_reg.match >= EXT_BASE) ? PH_MEXT : PH_IDLE;
    assign done       = (phase_next == PH_IDLE);
    assign q_pop      = q_valid && ((phase_reg == PH_IDLE) || (emit && done));

    always_comb
    begin
        phase_next = PH_IDLE;
        cur_byte   = job_reg.first_byte;
        rest_next  = rest_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                phase_next = PH_IDLE;
            end
            PH_FIRST:
            begin
                cur_byte = job_reg.first_byte;
                if (job_reg.zero_byte)
                begin
                    phase_next = PH_ZERO;
                end
                else if (job_reg.lit_ext)
                begin
                    phase_next = PH_LEXT;
                    rest_next  = job_reg.ext_len - EXT_BASE;
                end
                else
                begin
                    phase_next = fin_ph;
                end
            end
            PH_ZERO:
            begin
                cur_byte = 8'h00;
                if (job_reg.lit_ext)
                begin
                    phase_next = PH_LEXT;
                    rest_next  = job_reg.ext_len - EXT_BASE;
                end
                else
                begin
                    phase_next = fin_ph;
                end
            end
            PH_LEXT:
            begin
                cur_byte = chunk;
                if (chunk_full)
                begin
                    phase_next = PH_LEXT;
                    rest_next  = rest_reg - EXT_CHUNK;
                end
                else
                begin
                    phase_next = fin_ph;
                end
            end
            PH_OFF0:
            begin
                cur_byte   = job_reg.offset[7:0];
                phase_next = job_reg.short_form ? mext_ph : PH_OFF1;
                rest_next  = job_reg.match - EXT_BASE;
            end
            PH_OFF1:
            begin
                cur_byte   = job_reg.offset[15:8];
                phase_next = mext_ph;
                rest_next  = job_reg.match - EXT_BASE;
            end
            PH_MEXT:
            begin
                cur_byte = chunk;
                if (chunk_full)
                begin
                    phase_next = PH_MEXT;
                    rest_next  = rest_reg - EXT_CHUNK;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
            job_reg       <= '0;
            rest_reg      <= '0;
            out_byte_reg  <= '0;
            last_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                job_reg   <= q_data;
                phase_reg <= PH_FIRST;
            end
            else if (emit)
            begin
                phase_reg <= phase_next;
                rest_reg  <= rest_next;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                out_byte_reg  <= cur_byte;
                last_reg      <= done;
                done_reg      <= done && job_reg.fin;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### sv/lz_sequence_token_encoder_core.sv
// top level of the lz sequence token encoder
// with the back sequencer idle, an accepted item is written to the job queue, loaded into
// the back job register, then its first byte is registered onto the result ports
// throughput: one stream byte per cycle while pop keeps up, no gap between queued jobs
// a 4-entry job queue lets the front keep accepting while the back drains bytes
// reset is asynchronous, active low: queue and sequencer empty, min_match back to 4
`default_nettype none

module lz_sequence_token_encoder_core
    import lzenc_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic          cmd,
    input  wire logic [16:0]   match_offset,
    input  wire logic [12:0]   match_length,
    input  wire logic [12:0]   literal_count,
    input  wire logic [7:0]    literal_byte,
    output logic               empty,
    input  wire logic          pop,
    output logic [7:0]         out_byte,
    output logic               last,
    output logic               sequence_done,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [4:0]    cfg_data
);

    lzenc_job_t job;
    lzenc_job_t q_data;
    logic       job_push;
    logic       q_valid;
    logic       q_pop;

    assign cfg_ready = 1'b1;

    lzenc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .cmd           (cmd),
        .match_offset  (match_offset),
        .match_length  (match_length),
        .literal_count (literal_count),
        .literal_byte  (literal_byte),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .job           (job),
        .job_push      (job_push)
    );

    lzenc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_push),
        .wr_data  (job),
        .full     (full),
        .rd_en    (q_pop),
        .rd_data  (q_data),
        .rd_valid (q_valid)
    );

    lzenc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_data        (q_data),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .out_byte      (out_byte),
        .last          (last),
        .sequence_done (sequence_done)
    );

endmodule

`default_nettype wire

### dv/tb_lz_sequence_token_encoder_core.sv
// testbench for lz_sequence_token_encoder_core: directed and random sequences checked byte by byte
module tb_lz_sequence_token_encoder_core;
    import lzenc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_ITEMS  = 28;

    class lz_stream_board;
        typedef struct packed {
            logic [7:0] data;
            logic       last;
            logic       done;
        } stream_byte_t;

        stream_byte_t due_q[$];
        stream_byte_t step_q[$];
        logic [4:0]   min_match;
        logic [16:0]  seq_off;
        logic [12:0]  seq_match;
        logic [12:0]  lits_left;
        logic         short_tok;
        logic         lit_only;
        int           errors;
        int           checked;
        int           headers;
        int           literals;
        int           strays;

        function new();
            min_match = MIN_MATCH_RESET;
            seq_off   = '0;
            seq_match = '0;
            lits_left = '0;
            short_tok = 1'b0;
            lit_only  = 1'b0;
            errors    = 0;
            checked   = 0;
            headers   = 0;
            literals  = 0;
            strays    = 0;
        endfunction

        function logic [2:0] cap7(input logic [12:0] v);
            return (v < 13'd7) ? v[2:0] : 3'd7;
        endfunction

        function void add(input logic [7:0] b);
            stream_byte_t e;
            e.data = b;
            e.last = 1'b0;
            e.done = 1'b0;
            step_q = {step_q, e};
        endfunction

        function void add_ext(input int v);
            int rest;
            int chunk;
            rest = v - 7;
            do
            begin
                chunk = (rest > 255) ? 255 : rest;
                add(8'(chunk));
                rest -= 255;
            end
            while (chunk == 255);
        endfunction

        function void close_seq();
            if (!lit_only)
            begin
                add(seq_off[7:0]);
                if (!short_tok)
                    add(seq_off[15:8]);
                if (seq_match >= 13'd7)
                    add_ext(int'(seq_match));
            end
            if (step_q.size() > 0)
                step_q[step_q.size() - 1].done = 1'b1;
        endfunction

        function void note_item(input logic c, input logic [16:0] off, input logic [12:0] ml,
                                input logic [12:0] lc, input logic [7:0] lb);
            logic [12:0]  m;
            step_q.delete();
            if (c == CMD_HEADER)
            begin
                headers++;
                seq_off   = off;
                lits_left = lc;
                if (off == 17'd0)
                begin
                    lit_only  = 1'b1;
                    short_tok = 1'b0;
                    seq_match = '0;
                    add(8'h80 | 8'(cap7(lc)));
                    add(8'h00);
                    if (lc >= 13'd7)
                        add_ext(int'(lc));
                end
                else
                begin
                    m = (ml > 13'(min_match)) ? ml - 13'(min_match) : 13'd0;
                    lit_only  = 1'b0;
                    seq_match = m;
                    if (off < 17'd1024 && lc < 13'd4)
                    begin
                        short_tok = 1'b1;
                        add({1'b1, off[9:8], lc[1:0], cap7(m)});
                    end
                    else
                    begin
                        short_tok = 1'b0;
                        add({1'b0, off[16], cap7(lc), cap7(m)});
                        if (lc >= 13'd7)
                            add_ext(int'(lc));
                    end
                end
                if (lits_left == 13'd0)
                    close_seq();
            end
            else
            begin
                if (lits_left == 13'd0)
                begin
                    strays++;
                    return;
                end
                literals++;
                add(lb);
                lits_left--;
                if (lits_left == 13'd0)
                    close_seq();
            end
            step_q[step_q.size() - 1].last = 1'b1;
            due_q = {due_q, step_q};
        endfunction

        function void check_byte(input logic [7:0] b, input logic l, input logic d);
            stream_byte_t e;
            if (due_q.size() == 0)
            begin
                $error("unexpected result: out_byte %0h last %0b sequence_done %0b", b, l, d);
                errors++;
                return;
            end
            e = due_q.pop_front();
            checked++;
            if (b !== e.data)
            begin
                $error("out_byte: expected %0h, actual %0h", e.data, b);
                errors++;
            end
            if (l !== e.last)
            begin
                $error("last: expected %0b, actual %0b", e.last, l);
                errors++;
            end
            if (d !== e.done)
            begin
                $error("sequence_done: expected %0b, actual %0b", e.done, d);
                errors++;
            end
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        push          = 1'b0;
    logic        full;
    logic        cmd           = 1'b0;
    logic [16:0] match_offset  = '0;
    logic [12:0] match_length  = '0;
    logic [12:0] literal_count = '0;
    logic [7:0]  literal_byte  = '0;
    logic        empty;
    logic        pop           = 1'b0;
    logic [7:0]  out_byte;
    logic        last;
    logic        sequence_done;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data      = '0;

    lz_stream_board sb;
    bit             no_idle    = 1'b0;
    bit             open_seq   = 1'b0;
    bit             push_on    = 1'b0;
    int             pop_hold   = 0;
    int             cycles     = 0;
    int             settings   = 1;

    lz_sequence_token_encoder_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .cmd           (cmd),
        .match_offset  (match_offset),
        .match_length  (match_length),
        .literal_count (literal_count),
        .literal_byte  (literal_byte),
        .empty         (empty),
        .pop           (pop),
        .out_byte      (out_byte),
        .last          (last),
        .sequence_done (sequence_done),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 15);
        if (r < 9)
            return 0;
        if (r < 14)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (pop_hold > 0)
        begin
            pop_hold <= pop_hold - 1;
            pop      <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                pop_hold <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_byte(out_byte, last, sequence_done);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_item(input logic c, input logic [16:0] off, input logic [12:0] ml,
                             input logic [12:0] lc, input logic [7:0] lb);
        int gap;
        gap           = pick_gap();
        push          <= 1'b1;
        push_on       = 1'b1;
        cmd           <= c;
        match_offset  <= off;
        match_length  <= ml;
        literal_count <= lc;
        literal_byte  <= lb;
        do
            @(posedge clk);
        while (full);
        sb.note_item(c, off, ml, lc, lb);
        if (gap > 0)
        begin
            push    <= 1'b0;
            push_on = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_header(input logic [16:0] off, input logic [12:0] ml,
                               input logic [12:0] lc);
        send_item(CMD_HEADER, off, ml, lc, 8'($urandom));
        open_seq = (lc != 13'd0);
    endtask

    task automatic send_literal(input logic [7:0] b);
        send_item(CMD_LITERAL, 17'($urandom), 13'($urandom), 13'($urandom), b);
    endtask

    task automatic wait_idle();
        if (push_on)
        begin
            push    <= 1'b0;
            push_on = 1'b0;
        end
        while (sb.due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_min_match(input logic [4:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        sb.min_match = v;
        settings++;
    endtask

    task automatic directed_items();
        send_header(17'd0, 13'd0, 13'd0);
        send_literal(8'h3c);
        send_header(17'd0, 13'd5, 13'd3);
        send_literal(8'h00);
        send_literal(8'hff);
        send_literal(8'h5a);
        send_header(17'd1, 13'd4, 13'd0);
        send_header(17'd1023, 13'd2, 13'd3);
        send_literal(8'ha5);
        send_literal(8'h01);
        send_literal(8'h80);
        send_header(17'd1024, 13'd11, 13'd2);
        send_literal(8'h7f);
        send_literal(8'hfe);
        send_header(17'd5, 13'd20, 13'd7);
        repeat (7) send_literal(8'($urandom));
        // open sequences cut short by the next header
        send_header(17'd0, 13'd0, 13'd8191);
        send_literal(8'h11);
        send_header(17'd70000, 13'd266, 13'd262);
        send_literal(8'h22);
        send_header(17'd131071, 13'd8191, 13'd0);
    endtask

    task automatic random_sequence(inout int count);
        logic [16:0] off;
        logic [12:0] ml;
        logic [12:0] lc;
        int          mm;
        int          keep;
        int          r;
        mm = int'(sb.min_match);
        r  = $urandom_range(0, 9);
        if (r < 2)
            off = 17'd0;
        else if (r < 6)
            off = 17'($urandom_range(1, 1023));
        else
            off = 17'($urandom_range(1024, 131071));
        r = $urandom_range(0, 15);
        if (r < 10)
            lc = 13'($urandom_range(0, 6));
        else if (r < 13)
            lc = 13'($urandom_range(7, 30));
        else if (r == 13)
            lc = 13'($urandom_range(0, 3));
        else if (r == 14)
            lc = 13'($urandom_range(255, 270));
        else
            lc = 13'($urandom_range(271, 8191));
        r = $urandom_range(0, 9);
        if (off == 17'd0)
            ml = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 8191)) : 13'd0;
        else if (r < 6)
            ml = 13'(mm + $urandom_range(0, 12));
        else if (r < 8)
            ml = 13'(mm + $urandom_range(13, 600));
        else if (r == 8)
            ml = 13'($urandom_range(0, mm));
        else
            ml = 13'($urandom_range(0, 8191));
        keep = int'(lc);
        if (lc > 30 || (lc != 0 && $urandom_range(0, 9) == 0))
            keep = $urandom_range(0, (lc - 1 < 8) ? lc - 1 : 8);
        send_header(off, ml, lc);
        for (int k = 0; k < keep; k++)
            send_literal(8'($urandom));
        if (keep == lc)
            open_seq = 1'b0;
        count += 1 + keep;
    endtask

    task automatic random_phase(input int target);
        int count;
        count = 0;
        while (count < target)
        begin
            if (!open_seq && $urandom_range(0, 7) == 0)
                send_literal(8'($urandom));
            else
                random_sequence(count);
        end
    endtask

    initial
    begin
        int mm_set[5];
        mm_set = '{16, 1, 0, 31, -1};
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_items();
        random_phase(PHASE_ITEMS);
        for (int p = 0; p < 5; p++)
        begin
            write_min_match((mm_set[p] < 0) ? 5'($urandom_range(0, 31)) : 5'(mm_set[p]));
            no_idle = (p == 2);
            random_phase(PHASE_ITEMS);
        end
        no_idle = 1'b0;
        wait_idle();
        $display("run: %0d headers, %0d literal items, %0d ignored literals, %0d min_match settings",
                 sb.headers, sb.literals, sb.strays, settings);
        $display("run: %0d stream bytes compared, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.due_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
sv/lzenc_pkg.sv
sv/lzenc_front.sv
sv/lzenc_queue.sv
sv/lzenc_back.sv
sv/lz_sequence_token_encoder_core.sv
dv/tb_lz_sequence_token_encoder_core.sv
